// ----- design/fpfa_pkg.sv -----
// shared types and constants for the fixed partition fit allocator
`timescale 1ns / 1ps
`default_nettype none
package fpfa_pkg;

  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(PARTITIONS);
  localparam int CNT_W      = $clog2(PARTITIONS + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 1'd1;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;
  localparam logic [1:0] STRAT_NEXT  = 2'd3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [3:0]           partition_index;
    logic [15:0]          partition_size;
    logic [15:0]          request_size;
  } in_req_t;

  typedef struct packed {
    logic                 granted;
    logic [3:0]           chosen_index;
    logic [15:0]          leftover;
  } out_rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 ld_en;
    logic [IDX_W-1:0]     ld_addr;
    logic [SIZE_BITS-1:0] ld_size;
    logic                 mark_en;
    logic [IDX_W-1:0]     mark_addr;
  } store_cmd_t;

endpackage
`default_nettype wire

// ----- design/fpfa_store.sv -----
// partition size memory and used marks, registered read
`timescale 1ns / 1ps
`default_nettype none
module fpfa_store (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fpfa_pkg::store_cmd_t         cmd,
  output logic [fpfa_pkg::SIZE_BITS-1:0]    rd_size,
  output logic                              rd_used
);
  import fpfa_pkg::*;

  logic [SIZE_BITS-1:0]  size_mem [PARTITIONS];
  logic [PARTITIONS-1:0] used_r;
  logic [SIZE_BITS-1:0]  rd_size_r;
  logic                  rd_used_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      size_mem[cmd.ld_addr] <= cmd.ld_size;
    end
    if (cmd.rd_en) begin
      rd_size_r <= size_mem[cmd.rd_addr];
      rd_used_r <= used_r[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (cmd.ld_en) begin
        used_r[cmd.ld_addr] <= 1'b0;
      end
      if (cmd.mark_en) begin
        used_r[cmd.mark_addr] <= 1'b1;
      end
    end
  end

  assign rd_size = rd_size_r;
  assign rd_used = rd_used_r;

endmodule
`default_nettype wire

// ----- design/fpfa_scan.sv -----
// request sequencer: scans the table one entry per cycle and picks the fit
`timescale 1ns / 1ps
`default_nettype none
module fpfa_scan (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire fpfa_pkg::in_req_t           in_req,
  output logic                             out_valid,
  output fpfa_pkg::out_rsp_t               out_rsp,
  input  wire logic [1:0]                  strategy,
  input  wire logic [fpfa_pkg::CNT_W-1:0]  count,
  output fpfa_pkg::store_cmd_t             cmd,
  input  wire logic [fpfa_pkg::SIZE_BITS-1:0] rd_size,
  input  wire logic                        rd_used
);
  import fpfa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     issued_r, issued_nxt;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic                 eval_r, eval_nxt;
  logic [IDX_W-1:0]     eval_idx_r, eval_idx_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_rsp_t             out_r, out_nxt;

  logic                 accept;
  logic [SIZE_BITS-1:0] diff;
  logic                 fits;
  logic                 take;
  logic [CNT_W-1:0]     addr_inc;
  logic [CNT_W-1:0]     best_inc;

  assign accept   = start && (state_r == S_IDLE);
  assign diff     = rd_size - req_r;
  assign fits     = !rd_used && (rd_size >= req_r);
  assign take     = eval_r && fits &&
                    (!found_r ||
                     (strategy == STRAT_BEST  && diff < best_r) ||
                     (strategy == STRAT_WORST && diff > best_r));
  assign addr_inc = CNT_W'(addr_r) + CNT_W'(1);
  assign best_inc = CNT_W'(best_idx_r) + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    issued_nxt    = issued_r;
    addr_nxt      = addr_r;
    eval_nxt      = 1'b0;
    eval_idx_nxt  = eval_idx_r;
    req_nxt       = req_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept && in_req.mode == MODE_LOAD) begin
          cmd.ld_en   = 1'b1;
          cmd.ld_addr = IDX_W'(in_req.partition_index);
          cmd.ld_size = SIZE_BITS'(in_req.partition_size);
          ptr_nxt     = '0;
        end else if (accept) begin
          req_nxt   = SIZE_BITS'(in_req.request_size);
          cnt_nxt   = count;
          issued_nxt = '0;
          found_nxt = 1'b0;
          best_idx_nxt = '0;
          best_nxt  = '0;
          if (strategy == STRAT_NEXT && CNT_W'(ptr_r) < count) begin
            addr_nxt = ptr_r;
          end else begin
            addr_nxt = '0;
          end
          if (count == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          found_nxt    = 1'b1;
          best_idx_nxt = eval_idx_r;
          best_nxt     = diff;
        end
        if (issued_r != cnt_r) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_addr  = addr_r;
          eval_nxt     = 1'b1;
          eval_idx_nxt = addr_r;
          issued_nxt   = issued_r + CNT_W'(1);
          addr_nxt     = (addr_inc == cnt_r) ? '0 : addr_inc[IDX_W-1:0];
        end else if (!eval_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_nxt.granted      = 1'b1;
            out_nxt.chosen_index = 4'(best_idx_r);
            out_nxt.leftover     = 16'(best_r);
            cmd.mark_en          = (req_r != '0);
            cmd.mark_addr        = best_idx_r;
            if (strategy == STRAT_NEXT) begin
              if (best_r != '0) begin
                ptr_nxt = best_idx_r;
              end else begin
                ptr_nxt = (best_inc == cnt_r) ? '0 : best_inc[IDX_W-1:0];
              end
            end
          end else begin
            out_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eval_r      <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eval_r      <= eval_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    issued_r   <= issued_nxt;
    addr_r     <= addr_nxt;
    eval_idx_r <= eval_idx_nxt;
    req_r      <= req_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule
`default_nettype wire

// ----- design/fixed_partition_fit_allocator.sv -----
// top level of the fixed partition fit allocator
// A load request writes one partition and leaves busy low.
// An allocation request holds busy high while it scans the table (a count above
// 16 scans 16): the size memory delivers one entry per cycle to the fit compare,
// then the last read passes through the compare and the result is reported.
// Its result strobes on out_valid for one cycle right after busy drops; a request
// with partition_count of zero answers in the next cycle without raising busy.
// The receiver cannot stall: out_rsp is valid only while out_valid is high.
// cfg_ready is always high; configure only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module fixed_partition_fit_allocator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire fpfa_pkg::in_req_t                in_req,
  output logic                                  out_valid,
  output fpfa_pkg::out_rsp_t                    out_rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fpfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpfa_pkg::*;

  logic [1:0]           strategy_r;
  logic [4:0]           count_r;
  logic [CNT_W-1:0]     count_eff;
  store_cmd_t           cmd;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 rd_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= STRAT_FIRST;
      count_r    <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STRATEGY: strategy_r <= cfg_data[1:0];
        CFG_COUNT:    count_r    <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // clamp to the table depth
  assign count_eff = (32'(count_r) > PARTITIONS) ? CNT_W'(PARTITIONS) : CNT_W'(count_r);
  assign cfg_ready = 1'b1;

  fpfa_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_size (rd_size),
    .rd_used (rd_used)
  );

  fpfa_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .strategy  (strategy_r),
    .count     (count_eff),
    .cmd       (cmd),
    .rd_size   (rd_size),
    .rd_used   (rd_used)
  );

endmodule
`default_nettype wire

// ----- design/fpfa_checker.sv -----
// port-level checks for the fixed partition fit allocator, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module fpfa_port_checks (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire fpfa_pkg::in_req_t                in_req,
  input wire logic                             out_valid,
  input wire fpfa_pkg::out_rsp_t               out_rsp
);
  import fpfa_pkg::*;

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.mode == MODE_LOAD) |=> !out_valid)
    else $error("result after load request");

  // refused result carries zero index and leftover
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.granted) |-> (out_rsp.chosen_index == '0 &&
                                         out_rsp.leftover == '0))
    else $error("refused result not zeroed");

  // results appear only once the scan is over
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // busy rises only on an allocation request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(start) && $past(in_req.mode) == MODE_REQUEST))
    else $error("busy without allocation request");

  // end of scan always reports
  a_fall_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without result");

endmodule

bind fixed_partition_fit_allocator fpfa_port_checks u_fpfa_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
`default_nettype wire

// ----- tb/fpfa_checker.sv -----
// checker for the fixed partition fit allocator: predicts grants and compares results
`timescale 1ns / 1ps
module fpfa_checker
  import fpfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire in_req_t               in_req,
  input  wire logic                  out_valid,
  input  wire out_rsp_t              out_rsp,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         grants_pending
);

  logic [SIZE_BITS-1:0] part_size [PARTITIONS];
  logic                 part_used [PARTITIONS];
  logic [IDX_W-1:0]     next_ptr;
  logic [1:0]           strat;
  logic [4:0]           count_reg;
  out_rsp_t             grant_q [$];

  function automatic bit fits(int p, logic [SIZE_BITS-1:0] want);
    return !part_used[p] && part_size[p] >= want;
  endfunction

  function automatic out_rsp_t allocate(logic [SIZE_BITS-1:0] want);
    int                   cnt;
    int                   p;
    int                   pick;
    int                   nxt;
    bit                   found;
    logic [SIZE_BITS-1:0] margin;
    logic [SIZE_BITS-1:0] best_margin;
    out_rsp_t             rsp;
    cnt = (int'(count_reg) > PARTITIONS) ? PARTITIONS : int'(count_reg);
    pick = 0;
    found = 1'b0;
    best_margin = '0;
    rsp = '0;
    if (strat == STRAT_NEXT) begin
      p = (int'(next_ptr) < cnt) ? int'(next_ptr) : 0;
      for (int i = 0; i < cnt && !found; i++) begin
        if (fits(p, want)) begin
          pick = p;
          found = 1'b1;
        end else begin
          p = (p + 1 == cnt) ? 0 : p + 1;
        end
      end
    end else begin
      for (int i = 0; i < cnt; i++) begin
        if (fits(i, want)) begin
          margin = part_size[i] - want;
          if (!found || (strat == STRAT_BEST && margin < best_margin) ||
              (strat == STRAT_WORST && margin > best_margin)) begin
            pick = i;
            best_margin = margin;
            found = 1'b1;
          end
        end
      end
    end
    if (found) begin
      rsp.granted = 1'b1;
      rsp.chosen_index = pick[3:0];
      rsp.leftover = part_size[pick] - want;
      if (want != '0) part_used[pick] = 1'b1;
      if (strat == STRAT_NEXT) begin
        nxt = (pick + 1 == cnt) ? 0 : pick + 1;
        next_ptr = (rsp.leftover != '0) ? pick[IDX_W-1:0] : nxt[IDX_W-1:0];
      end
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    if (!rst_n) begin
      for (int p = 0; p < PARTITIONS; p++) part_used[p] = 1'b0;
      next_ptr = '0;
      strat = STRAT_FIRST;
      count_reg = 5'd16;
      fail_count = 0;
      grant_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STRATEGY: strat = cfg_data[1:0];
          CFG_COUNT:    count_reg = cfg_data;
          default:      ;
        endcase
      end
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result: granted=%0d index=%0d leftover=%0d",
                     $time, out_rsp.granted, out_rsp.chosen_index, out_rsp.leftover);
          fail_count++;
        end else begin
          exp_rsp = grant_q.pop_front();
          if (out_rsp.granted !== exp_rsp.granted ||
              out_rsp.chosen_index !== exp_rsp.chosen_index ||
              out_rsp.leftover !== exp_rsp.leftover) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       $time, exp_rsp.granted, exp_rsp.chosen_index, exp_rsp.leftover,
                       out_rsp.granted, out_rsp.chosen_index, out_rsp.leftover);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_req.mode == MODE_LOAD) begin
          part_size[in_req.partition_index] = in_req.partition_size;
          part_used[in_req.partition_index] = 1'b0;
          next_ptr = '0;
        end else begin
          grant_q.push_back(allocate(in_req.request_size));
        end
      end
    end
    grants_pending = grant_q.size();
  end

endmodule

// ----- tb/tb_fixed_partition_fit_allocator.sv -----
// testbench top for the fixed partition fit allocator: stimulus and verdict
`timescale 1ns / 1ps
module tb_fixed_partition_fit_allocator;
  import fpfa_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_req_t               in_req;
  logic                  out_valid;
  out_rsp_t              out_rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    grants_pending;
  int                    idle_pct;
  logic [15:0]           loaded_size [PARTITIONS];

  fixed_partition_fit_allocator i_dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  fpfa_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .grants_pending
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_size(int lo, int hi);
    logic [31:0] r;
    r = $urandom_range(lo, hi);
    return r[15:0];
  endfunction

  task automatic issue(in_req_t item);
    start <= 1'b1;
    in_req <= item;
    do @(posedge clk); while (busy);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic send_load(logic [3:0] idx, logic [15:0] sz);
    in_req_t item;
    item.mode = MODE_LOAD;
    item.partition_index = idx;
    item.partition_size = sz;
    item.request_size = pick_size(0, 65535);
    loaded_size[idx] = sz;
    issue(item);
  endtask

  task automatic send_request(logic [15:0] sz);
    in_req_t     item;
    logic [31:0] r;
    r = $urandom;
    item.mode = MODE_REQUEST;
    item.partition_index = r[3:0];
    item.partition_size = pick_size(0, 65535);
    item.request_size = sz;
    issue(item);
  endtask

  // wait until every outstanding request has been answered
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (grants_pending != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_cfg(logic [1:0] strategy, logic [4:0] cnt);
    logic [31:0] r;
    r = $urandom;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STRATEGY;
    cfg_data <= {r[2:0], strategy};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_COUNT;
    cfg_data <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] sz;
    logic [31:0] r;
    logic [4:0]  cnt;
    int          load_pct;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_cfg(STRAT_FIRST, 5'd16);
    for (int p = 0; p < PARTITIONS; p++) begin
      case (p)
        0:       sz = 16'd100;
        1:       sz = '0;
        2, 14:   sz = '1;
        3, 4, 6: sz = 16'd40;
        5, 7:    sz = 16'd300;
        11:      sz = 16'd500;
        default: sz = pick_size(60, 99);
      endcase
      send_load(p[3:0], sz);
    end
    send_request(16'd50);
    settle();
    set_cfg(STRAT_BEST, 5'd16);
    send_request(16'd40);
    send_request('0);
    settle();
    set_cfg(STRAT_WORST, 5'd16);
    send_request(16'd1);
    send_request('1);
    settle();
    set_cfg(STRAT_NEXT, 5'd16);
    send_request(16'd70);
    send_request(16'd230);
    send_request(16'd500);
    // pointer now beyond the narrowed table
    settle();
    set_cfg(STRAT_NEXT, 5'd4);
    send_request('0);
    send_request(16'd20);
    settle();
    set_cfg(STRAT_NEXT, 5'd0);
    send_request(16'd1);
    settle();
    set_cfg(STRAT_FIRST, 5'd31);
    send_request('1);
    send_load(4'd2, 16'd7);
    send_request(16'd7);

    for (int seg = 0; seg < 12; seg++) begin
      settle();
      idle_pct = (seg < 4) ? 13 : (seg < 8) ? 61 : 0;
      load_pct = $urandom_range(10, 40);
      case (seg)
        0:       cnt = 5'd16;
        1:       cnt = 5'd1;
        2:       cnt = 5'd31;
        3:       cnt = 5'd0;
        4:       cnt = 5'd17;
        5:       cnt = 5'd2;
        default: begin
          r = $urandom_range(1, 16);
          cnt = r[4:0];
        end
      endcase
      set_cfg(seg[1:0], cnt);
      repeat (130) begin
        r = $urandom;
        if ($urandom_range(0, 99) < load_pct) begin
          case ($urandom_range(0, 9))
            0:       sz = '0;
            1:       sz = '1;
            2, 3:    sz = pick_size(0, 65535);
            default: sz = pick_size(1, 8) * 16'd25;
          endcase
          send_load(r[3:0], sz);
        end else begin
          case ($urandom_range(0, 9))
            0:       sz = '0;
            1:       sz = '1;
            2:       sz = pick_size(0, 65535);
            3, 4:    sz = loaded_size[r[7:4]];
            default: sz = pick_size(1, 200);
          endcase
          send_request(sz);
        end
      end
    end

    settle();
    if (fail_count == 0 && grants_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
